// File: hw/rtl/pipz_pkg.sv
// ----------------------------------------------------------------------------
// pipz_pkg
// Shared widths, zone constants and types for the point-in-polygon zone block.
// ----------------------------------------------------------------------------
package pipz_pkg;

  localparam int FRAC_BITS_DEF = 4;
  localparam int PT_W          = 17;
  localparam int VERT_W        = 16;
  localparam int ZIDX_W        = 8;

  localparam int ZONE_HALF = 3000;
  localparam int ZONE_EDGE = 2999;
  localparam int ZONE_STEP = 500;
  localparam int ZONE_COLS = 12;

  typedef struct packed {
    logic              ok;
    logic [ZIDX_W-1:0] idx;
  } zone_t;

endpackage

// File: hw/rtl/tri_quad_point_in_polygon_zone.sv
// ----------------------------------------------------------------------------
// tri_quad_point_in_polygon_zone
// Even-odd crossing test of a point against a triangle or quad, plus the
// 12x12 zone index of the point.
//
//   port group     dir   handshake      contents
//   command        in    start / busy   point_x, point_y, is_quad, vert_*
//   result         out   done           inside_res, zone_valid, zone_index
//
// one beat per cycle, busy is never raised
// a result appears for one cycle once its command beat has passed the input
// register, the product register of the edge units and the result register
// rst clears the pipeline valid bits only; results cannot be stalled
// ----------------------------------------------------------------------------
module tri_quad_point_in_polygon_zone import pipz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PT_W-1:0]   point_x,
  input  logic signed [PT_W-1:0]   point_y,
  input  logic                    is_quad,
  input  logic signed [VERT_W-1:0] vert_x0,
  input  logic signed [VERT_W-1:0] vert_y0,
  input  logic signed [VERT_W-1:0] vert_x1,
  input  logic signed [VERT_W-1:0] vert_y1,
  input  logic signed [VERT_W-1:0] vert_x2,
  input  logic signed [VERT_W-1:0] vert_y2,
  input  logic signed [VERT_W-1:0] vert_x3,
  input  logic signed [VERT_W-1:0] vert_y3,
  output logic                    done,
  output logic                    inside_res,
  output logic                    zone_valid,
  output logic [ZIDX_W-1:0]       zone_index
);

  localparam int VW = VERT_W + FRAC_BITS;

  logic                    vld0, vld1;
  logic signed [PT_W-1:0]   px, py;
  logic                    quad;
  logic signed [VERT_W-1:0] vx [4];
  logic signed [VERT_W-1:0] vy [4];

  logic signed [VW-1:0] sx [4];
  logic signed [VW-1:0] sy [4];
  logic signed [VW-1:0] e1x, e1y;
  logic [3:0]           crossing;
  zone_t                zone;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld0 <= start && !busy;
      vld1 <= vld0;
      done <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    px    <= point_x;
    py    <= point_y;
    quad  <= is_quad;
    vx[0] <= vert_x0;
    vy[0] <= vert_y0;
    vx[1] <= vert_x1;
    vy[1] <= vert_y1;
    vx[2] <= vert_x2;
    vy[2] <= vert_y2;
    vx[3] <= vert_x3;
    vy[3] <= vert_y3;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sx[i] = VW'(vx[i]) <<< FRAC_BITS;
      sy[i] = VW'(vy[i]) <<< FRAC_BITS;
    end
    e1x = quad ? sx[3] : sx[2];
    e1y = quad ? sy[3] : sy[2];
  end

  // quad edges 0-1 1-3 2-0 3-2, triangle edges 0-1 1-2 2-0
  pipz_edge #(.FRAC_BITS(FRAC_BITS)) u_edge0 (
    .clk(clk), .en(1'b1), .ax(sx[0]), .ay(sy[0]), .bx(sx[1]), .by(sy[1]),
    .px(px), .py(py), .crossing(crossing[0])
  );

  pipz_edge #(.FRAC_BITS(FRAC_BITS)) u_edge1 (
    .clk(clk), .en(1'b1), .ax(sx[1]), .ay(sy[1]), .bx(e1x), .by(e1y),
    .px(px), .py(py), .crossing(crossing[1])
  );

  pipz_edge #(.FRAC_BITS(FRAC_BITS)) u_edge2 (
    .clk(clk), .en(1'b1), .ax(sx[2]), .ay(sy[2]), .bx(sx[0]), .by(sy[0]),
    .px(px), .py(py), .crossing(crossing[2])
  );

  pipz_edge #(.FRAC_BITS(FRAC_BITS)) u_edge3 (
    .clk(clk), .en(quad), .ax(sx[3]), .ay(sy[3]), .bx(sx[2]), .by(sy[2]),
    .px(px), .py(py), .crossing(crossing[3])
  );

  pipz_zone #(.FRAC_BITS(FRAC_BITS)) u_zone (
    .clk(clk), .px(px), .py(py), .zone(zone)
  );

  always_ff @(posedge clk) begin
    inside_res <= ^crossing;
    zone_valid <= zone.ok;
    zone_index <= zone.idx;
  end

endmodule

// File: hw/rtl/pipz_edge.sv
// ----------------------------------------------------------------------------
// pipz_edge
// One polygon edge: registers the straddle test and both cross products,
// then compares them to tell whether the edge crosses the ray to the right.
// ----------------------------------------------------------------------------
module pipz_edge import pipz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [VERT_W+FRAC_BITS-1:0]  ax,
  input  logic signed [VERT_W+FRAC_BITS-1:0]  ay,
  input  logic signed [VERT_W+FRAC_BITS-1:0]  bx,
  input  logic signed [VERT_W+FRAC_BITS-1:0]  by,
  input  logic signed [PT_W-1:0]              px,
  input  logic signed [PT_W-1:0]              py,
  output logic                                crossing
);

  localparam int VW = VERT_W + FRAC_BITS;
  localparam int DW = ((VW > PT_W) ? VW : PT_W) + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ax_w, ay_w, bx_w, by_w, px_w, py_w;
  logic signed [DW-1:0] dy, dxp, dxe, dyp;
  logic signed [PW-1:0] lhs_next, rhs_next;
  logic                 straddle_next;

  logic signed [PW-1:0] lhs, rhs;
  logic                 straddle, dy_neg;

  always_comb begin
    ax_w = DW'(ax);
    ay_w = DW'(ay);
    bx_w = DW'(bx);
    by_w = DW'(by);
    px_w = DW'(px);
    py_w = DW'(py);
    dy   = by_w - ay_w;
    dxp  = px_w - ax_w;
    dxe  = bx_w - ax_w;
    dyp  = py_w - ay_w;
    lhs_next = PW'(dxp) * PW'(dy);
    rhs_next = PW'(dxe) * PW'(dyp);
    straddle_next = en && ((ay_w > py_w) != (by_w > py_w));
  end

  always_ff @(posedge clk) begin
    lhs      <= lhs_next;
    rhs      <= rhs_next;
    straddle <= straddle_next;
    dy_neg   <= dy[DW-1];
  end

  assign crossing = straddle && (dy_neg ? (lhs > rhs) : (lhs < rhs));

endmodule

// File: hw/rtl/pipz_zone.sv
// ----------------------------------------------------------------------------
// pipz_zone
// Range check and 500-unit cell lookup of the query point, registered, then
// folded into a row-major index.
// ----------------------------------------------------------------------------
module pipz_zone import pipz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic signed [PT_W-1:0] px,
  input  logic signed [PT_W-1:0] py,
  output zone_t                 zone
);

  localparam int LIM  = ZONE_HALF << FRAC_BITS;
  localparam int CLP  = ZONE_EDGE << FRAC_BITS;
  localparam int STP  = ZONE_STEP << FRAC_BITS;
  localparam int OW   = $clog2(2 * LIM + 1);
  localparam int XW   = ((OW > PT_W) ? OW : PT_W) + 1;
  localparam int CW   = $clog2(ZONE_COLS);

  localparam logic signed [XW-1:0] LIM_P = XW'(LIM);
  localparam logic signed [XW-1:0] LIM_N = XW'(-LIM);
  localparam logic signed [XW-1:0] CLP_P = XW'(CLP);

  function automatic logic [CW-1:0] cell_of(input logic signed [XW-1:0] c);
    logic signed [XW-1:0] cc;
    logic [OW-1:0]        off;
    logic [CW-1:0]        cnt;
    cc  = (c == LIM_P) ? CLP_P : c;
    off = OW'(cc + LIM_P);
    cnt = '0;
    for (int k = 1; k < ZONE_COLS; k++) begin
      if (off >= OW'(k * STP)) begin
        cnt = cnt + CW'(1);
      end
    end
    return cnt;
  endfunction

  logic signed [XW-1:0] px_w, py_w;
  logic                 ok_next;

  logic          ok;
  logic [CW-1:0] col, row;

  always_comb begin
    px_w    = XW'(px);
    py_w    = XW'(py);
    ok_next = (px_w >= LIM_N) && (px_w <= LIM_P) && (py_w >= LIM_N) && (py_w <= LIM_P);
  end

  always_ff @(posedge clk) begin
    ok  <= ok_next;
    col <= cell_of(px_w);
    row <= cell_of(py_w);
  end

  always_comb begin
    zone.ok  = ok;
    zone.idx = ok ? (ZIDX_W'(row) * ZIDX_W'(ZONE_COLS) + ZIDX_W'(col)) : '0;
  end

endmodule

// File: hw/rtl/pipz_checker.sv
// ----------------------------------------------------------------------------
// pipz_checker
// Port-level checks of the point-in-polygon zone block, bound to the top.
// ----------------------------------------------------------------------------
module pipz_checker import pipz_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              zone_valid,
  input logic [ZIDX_W-1:0] zone_index
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("command beat without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("result without command beat");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !zone_valid |-> zone_index == '0)
    else $error("zone index set while out of range");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    done |-> zone_index < ZIDX_W'(ZONE_COLS * ZONE_COLS))
    else $error("zone index beyond grid");

endmodule

bind tri_quad_point_in_polygon_zone pipz_checker u_pipz_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .zone_valid(zone_valid),
  .zone_index(zone_index)
);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tri_quad_point_in_polygon_zone. Query beats are
// driven through start / busy and every one is predicted on acceptance: the
// even-odd crossing test is redone with exact wide integer arithmetic and the
// zone cell is worked out from the scaled point. Each done beat is compared
// with the oldest prediction. A short directed set comes first (zone edges,
// field extremes, horizontal and degenerate edges, both polygon kinds), then
// random queries, mostly small polygons built round the point, with bursts
// of sender idling.
// ----------------------------------------------------------------------------
module tb import pipz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   quad;
    logic [3:0][VERT_W-1:0] vx;
    logic [3:0][VERT_W-1:0] vy;
  } query_t;

  typedef struct packed {
    logic  in_poly;
    zone_t zone;
  } answer_t;

  class polygon_board;
    answer_t     pending_answers[$];
    int unsigned mismatches;

    function longint zone_cell(longint c, longint scale);
      if (c == ZONE_HALF * scale) c = ZONE_EDGE * scale;
      return (c + ZONE_HALF * scale) / (ZONE_STEP * scale);
    endfunction

    function answer_t predict_inside_zone(query_t q);
      longint  scale, px, py, lim, dy, lhs, rhs;
      longint  vxs[4], vys[4];
      int      nxt[4];
      int      n, j;
      logic    odd, hit;
      answer_t a;
      scale = longint'(1) << FRAC_BITS_DEF;
      px = longint'($signed(q.px));
      py = longint'($signed(q.py));
      for (int i = 0; i < 4; i++) begin
        vxs[i] = longint'($signed(q.vx[i])) * scale;
        vys[i] = longint'($signed(q.vy[i])) * scale;
      end
      if (q.quad) begin
        n = 4;
        nxt = '{1, 3, 0, 2};
      end else begin
        n = 3;
        nxt = '{1, 2, 0, 0};
      end
      odd = 1'b0;
      for (int i = 0; i < n; i++) begin
        j = nxt[i];
        if ((vys[i] > py) != (vys[j] > py)) begin
          dy  = vys[j] - vys[i];
          lhs = (px - vxs[i]) * dy;
          rhs = (vxs[j] - vxs[i]) * (py - vys[i]);
          hit = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
          if (hit) odd = ~odd;
        end
      end
      lim = ZONE_HALF * scale;
      a.in_poly = odd;
      a.zone.ok = (px >= -lim) && (px <= lim) && (py >= -lim) && (py <= lim);
      a.zone.idx = '0;
      if (a.zone.ok)
        a.zone.idx = ZIDX_W'(ZONE_COLS * zone_cell(py, scale) + zone_cell(px, scale));
      return a;
    endfunction

    function void note_query(query_t q);
      pending_answers.push_back(predict_inside_zone(q));
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $error("result beat with no query outstanding");
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.in_poly !== want.in_poly) begin
        $error("inside_res: expected %0d, got %0d", want.in_poly, got.in_poly);
        mismatches++;
      end
      if (got.zone.ok !== want.zone.ok) begin
        $error("zone_valid: expected %0d, got %0d", want.zone.ok, got.zone.ok);
        mismatches++;
      end
      if (got.zone.idx !== want.zone.idx) begin
        $error("zone_index: expected %0d, got %0d", want.zone.idx, got.zone.idx);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [PT_W-1:0]   point_x = '0;
  logic signed [PT_W-1:0]   point_y = '0;
  logic                     is_quad = 1'b0;
  logic signed [VERT_W-1:0] vert_x0 = '0;
  logic signed [VERT_W-1:0] vert_y0 = '0;
  logic signed [VERT_W-1:0] vert_x1 = '0;
  logic signed [VERT_W-1:0] vert_y1 = '0;
  logic signed [VERT_W-1:0] vert_x2 = '0;
  logic signed [VERT_W-1:0] vert_y2 = '0;
  logic signed [VERT_W-1:0] vert_x3 = '0;
  logic signed [VERT_W-1:0] vert_y3 = '0;
  logic                     done;
  logic                     inside_res;
  logic                     zone_valid;
  logic [ZIDX_W-1:0]        zone_index;

  polygon_board board;

  tri_quad_point_in_polygon_zone u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .point_x   (point_x),
    .point_y   (point_y),
    .is_quad   (is_quad),
    .vert_x0   (vert_x0),
    .vert_y0   (vert_y0),
    .vert_x1   (vert_x1),
    .vert_y1   (vert_y1),
    .vert_x2   (vert_x2),
    .vert_y2   (vert_y2),
    .vert_x3   (vert_x3),
    .vert_y3   (vert_y3),
    .done      (done),
    .inside_res(inside_res),
    .zone_valid(zone_valid),
    .zone_index(zone_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("tb failed");
    $finish;
  end

  always @(posedge clk) begin
    answer_t got;
    if (!rst && done) begin
      got.in_poly  = inside_res;
      got.zone.ok  = zone_valid;
      got.zone.idx = zone_index;
      board.check_answer(got);
    end
  end

  function automatic query_t make_query(int px, int py, bit quad, int x0, int y0,
                                        int x1, int y1, int x2, int y2, int x3, int y3);
    query_t q;
    q.px    = PT_W'(px);
    q.py    = PT_W'(py);
    q.quad  = quad;
    q.vx[0] = VERT_W'(x0);
    q.vy[0] = VERT_W'(y0);
    q.vx[1] = VERT_W'(x1);
    q.vy[1] = VERT_W'(y1);
    q.vx[2] = VERT_W'(x2);
    q.vy[2] = VERT_W'(y2);
    q.vx[3] = VERT_W'(x3);
    q.vy[3] = VERT_W'(y3);
    return q;
  endfunction

  function automatic int zone_edge_coord();
    int picks[12] = '{48000, -48000, 48001, -48001, 47999, -47999, 0, 8000,
                      -40000, 39999, 65535, -65536};
    return picks[$urandom_range(0, 11)];
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     mode, px, py, bx, by;
    mode = $urandom_range(0, 9);
    q.quad = 1'($urandom_range(0, 1));
    if (mode < 3) begin
      q.px = PT_W'($urandom());
      q.py = PT_W'($urandom());
      for (int i = 0; i < 4; i++) begin
        q.vx[i] = VERT_W'($urandom());
        q.vy[i] = VERT_W'($urandom());
      end
      if (mode == 2) begin
        q.px = PT_W'(zone_edge_coord());
        q.py = PT_W'(zone_edge_coord());
      end
    end else begin
      // small polygon round the point, sometimes sharing its grid lines
      px = int'($urandom_range(0, 96000)) - 48000;
      py = int'($urandom_range(0, 96000)) - 48000;
      if ($urandom_range(0, 3) == 0) px = px & ~15;
      if ($urandom_range(0, 2) == 0) py = py & ~15;
      q.px = PT_W'(px);
      q.py = PT_W'(py);
      bx = px >>> FRAC_BITS_DEF;
      by = py >>> FRAC_BITS_DEF;
      for (int i = 0; i < 4; i++) begin
        q.vx[i] = VERT_W'(bx + int'($urandom_range(0, 24)) - 12);
        q.vy[i] = VERT_W'(by + int'($urandom_range(0, 24)) - 12);
        if ($urandom_range(0, 5) == 0) q.vy[i] = VERT_W'(by);
      end
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    start   <= 1'b1;
    point_x <= q.px;
    point_y <= q.py;
    is_quad <= q.quad;
    vert_x0 <= q.vx[0];
    vert_y0 <= q.vy[0];
    vert_x1 <= q.vx[1];
    vert_y1 <= q.vy[1];
    vert_x2 <= q.vx[2];
    vert_y2 <= q.vy[2];
    vert_x3 <= q.vx[3];
    vert_y3 <= q.vy[3];
    do @(posedge clk); while (busy);
    board.note_query(q);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_answers.size() != 0);
  endtask

  initial begin
    query_t      directed[$];
    int unsigned idle_pct;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ten-unit square and twenty-unit right triangle, in and out
    directed.push_back(make_query(80, 80, 1, 0, 0, 10, 0, 0, 10, 10, 10));
    directed.push_back(make_query(200, 80, 1, 0, 0, 10, 0, 0, 10, 10, 10));
    directed.push_back(make_query(48, 48, 0, 0, 0, 20, 0, 0, 20, -32768, 32767));
    directed.push_back(make_query(240, 240, 0, 0, 0, 20, 0, 0, 20, 5, 5));
    // zone corners, clamp at the top edge, just outside, cell boundaries
    directed.push_back(make_query(48000, 48000, 1, 2990, 2990, 3010, 2990, 2990, 3010,
                                  3010, 3010));
    directed.push_back(make_query(-48000, -48000, 0, -3010, -3010, -2990, -3010, -3010,
                                  -2990, 0, 0));
    directed.push_back(make_query(48001, 0, 1, 0, 0, 1, 1, 2, 2, 3, 3));
    directed.push_back(make_query(0, -48001, 0, 0, 0, 1, 1, 2, 2, 3, 3));
    directed.push_back(make_query(-40000, 40000, 0, -2600, 2400, -2400, 2600, -2600,
                                  2600, 0, 0));
    directed.push_back(make_query(39999, -8000, 1, 2400, -600, 2600, -600, 2400, -400,
                                  2600, -400));
    // field extremes
    directed.push_back(make_query(-65536, 65535, 1, -32768, -32768, 32767, -32768,
                                  -32768, 32767, 32767, 32767));
    directed.push_back(make_query(65535, -65536, 0, 32767, 32767, -32768, -32768,
                                  32767, -32768, -1, -1));
    directed.push_back(make_query(0, 0, 1, -32768, -32768, 32767, -32768, -32768,
                                  32767, 32767, 32767));
    directed.push_back(make_query(-1, -1, 0, -32768, 32767, 32767, 32767, 0, -32768,
                                  0, 0));
    // horizontal edges through the point
    directed.push_back(make_query(16, 32, 0, 0, 2, 10, 2, 5, 8, 0, 0));
    directed.push_back(make_query(16, 32, 1, 0, 2, 10, 2, 0, 8, 10, 8));
    // point level with a vertex, point on an edge
    directed.push_back(make_query(40, 80, 0, 0, 0, 10, 5, 0, 10, 0, 0));
    directed.push_back(make_query(80, 0, 1, 0, 0, 10, 0, 0, 10, 10, 10));
    directed.push_back(make_query(0, 80, 1, 0, 0, 10, 0, 0, 10, 10, 10));
    // degenerate polygons
    directed.push_back(make_query(16, 16, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    directed.push_back(make_query(32, 32, 0, 0, 0, 2, 2, 4, 4, 0, 0));
    directed.push_back(make_query(8, 24, 1, 0, 0, 2, 4, 0, 4, 2, 0));
    directed.push_back(make_query(-24, -40, 0, -5, -5, 5, -5, -5, 5, 100, 100));

    foreach (directed[i]) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 11));
      send_query(directed[i]);
    end
    drain_answers();

    idle_pct = 0;
    for (int k = 0; k < 500; k++) begin
      if (k % 50 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      if (k >= 440) idle_pct = 0;
      if (k == 250) drain_answers();
      else if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 11));
      send_query(random_query());
    end

    drain_answers();
    repeat (6) @(posedge clk);
    if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
      $display("tb passed");
    end else begin
      if (board.pending_answers.size() != 0)
        $error("%0d results never arrived", board.pending_answers.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pipz_pkg.sv
hw/rtl/pipz_edge.sv
hw/rtl/pipz_zone.sv
hw/rtl/tri_quad_point_in_polygon_zone.sv
hw/rtl/pipz_checker.sv
test/tb.sv
